FILE: rtl/mmpp_pkg.sv
// Shared types, widths and constants of the min/max peak pyramid.
package mmpp_pkg;

  localparam int BLOCK_DEFAULT      = 256;
  localparam int MAX_LEVELS_DEFAULT = 4;
  localparam int LEVEL_CAP          = 8;
  localparam int QUEUE_DEPTH        = 4;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 2;
  localparam int BUCKET_W = 24;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-3:0] REG_FRAME_COUNT = '0;
  localparam logic [DATA_W-1:0] FRAME_COUNT_RESET = DATA_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_sample;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]         level_index;
    logic [BUCKET_W-1:0]        bucket_number;
    logic signed [SAMPLE_W-1:0] bucket_min;
    logic signed [SAMPLE_W-1:0] bucket_max;
    logic                       run_end;
  } out_word_t;

  typedef logic [LEVEL_CAP-1:0][DATA_W:0] threshold_table_t;

  // Entry L holds block to the power L+1, saturated at 2^32.
  function automatic threshold_table_t threshold_table(input int block);
    threshold_table_t t;
    logic [63:0]      p;
    logic [63:0]      cap;
    cap = 64'd1 << DATA_W;
    p   = 64'(block);
    for (int i = 0; i < LEVEL_CAP; i++) begin
      t[i] = (p > cap) ? cap[DATA_W:0] : p[DATA_W:0];
      p = (p > cap) ? p : p * 64'(block);
    end
    return t;
  endfunction

endpackage

FILE: rtl/mmpp_fifo.sv
// Small register queue used on both sides of the pyramid engine.
module mmpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/mmpp_back.sv
// Level engine: folds words in one level per cycle unless out_full; emits buckets.
module mmpp_back #(
  parameter int BLOCK      = 256,
  parameter int MAX_LEVELS = 4,
  localparam int LV_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  mmpp_pkg::in_word_t  head,
  input  logic                head_valid,
  output logic                head_pop,
  input  logic [LV_W-1:0]     top_lv,
  output mmpp_pkg::out_word_t out_word,
  output logic                out_push,
  input  logic                out_full
);
  import mmpp_pkg::*;

  localparam int FILL_W = $clog2(BLOCK + 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(BLOCK);
  localparam logic [FILL_W-1:0] AF_FILL   = FILL_W'(BLOCK - 1);

  logic signed [SAMPLE_W-1:0] level_min   [MAX_LEVELS];
  logic signed [SAMPLE_W-1:0] level_max   [MAX_LEVELS];
  logic [FILL_W-1:0]          level_fill  [MAX_LEVELS];
  logic [BUCKET_W-1:0]        level_count [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]      almost_full;

  logic                       busy;
  logic [LV_W-1:0]            lv;
  logic                       fin;
  logic                       carry_valid;
  logic signed [SAMPLE_W-1:0] carry_lo;
  logic signed [SAMPLE_W-1:0] carry_hi;

  logic                       step_go;
  logic [LV_W-1:0]            s_lv;
  logic [LV_W-1:0]            nxt;
  logic                       s_fin;
  logic                       s_in;
  logic signed [SAMPLE_W-1:0] s_lo;
  logic signed [SAMPLE_W-1:0] s_hi;
  logic [FILL_W-1:0]          cur_fill;
  logic [FILL_W-1:0]          new_fill;
  logic signed [SAMPLE_W-1:0] new_min;
  logic signed [SAMPLE_W-1:0] new_max;
  logic                       full;
  logic                       emitting;
  logic                       top;
  logic                       done;
  logic                       next_af;
  logic                       last;

  always_comb begin
    step_go  = (busy || head_valid) && !out_full;
    s_lv     = busy ? lv : '0;
    s_fin    = busy ? fin : head.final_sample;
    s_in     = busy ? carry_valid : 1'b1;
    s_lo     = busy ? carry_lo : head.sample;
    s_hi     = busy ? carry_hi : head.sample;
    cur_fill = level_fill[s_lv];
    new_fill = s_in ? cur_fill + FILL_W'(1) : cur_fill;
    new_min  = level_min[s_lv];
    new_max  = level_max[s_lv];
    if (s_in && (cur_fill == '0 || s_lo < level_min[s_lv])) begin
      new_min = s_lo;
    end
    if (s_in && (cur_fill == '0 || s_hi > level_max[s_lv])) begin
      new_max = s_hi;
    end
    full     = (new_fill == FULL_FILL);
    emitting = full || (s_fin && new_fill != '0);
    top      = (s_lv == top_lv);
    done     = top || (!s_fin && !full);
    nxt      = s_lv + LV_W'(1);
    next_af  = (int'(nxt) < MAX_LEVELS) ? almost_full[nxt] : 1'b0;
    last     = s_fin ? top : (top || !next_af);

    head_pop = step_go && !busy;
    out_push = step_go && emitting;
    out_word.level_index   = LEVEL_W'(s_lv);
    out_word.bucket_number = level_count[s_lv];
    out_word.bucket_min    = new_min;
    out_word.bucket_max    = new_max;
    out_word.run_end       = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      lv          <= '0;
      fin         <= 1'b0;
      carry_valid <= 1'b0;
      almost_full <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_min[i]   <= '0;
        level_max[i]   <= '0;
        level_fill[i]  <= '0;
        level_count[i] <= '0;
      end
    end else if (step_go) begin
      busy        <= !done;
      lv          <= done ? '0 : nxt;
      fin         <= s_fin;
      carry_valid <= emitting;
      carry_lo    <= new_min;
      carry_hi    <= new_max;
      if (done && s_fin) begin
        almost_full <= '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
          level_min[i]   <= '0;
          level_max[i]   <= '0;
          level_fill[i]  <= '0;
          level_count[i] <= '0;
        end
      end else begin
        level_min[s_lv]   <= new_min;
        level_max[s_lv]   <= new_max;
        level_fill[s_lv]  <= emitting ? '0 : new_fill;
        almost_full[s_lv] <= !emitting && (new_fill == AF_FILL);
        if (emitting) begin
          level_count[s_lv] <= level_count[s_lv] + BUCKET_W'(1);
        end
      end
    end
  end

  a_busy_above_base: assert property (@(posedge clk) disable iff (rst)
    busy |-> lv != '0)
    else $error("Engine busy at the base level.");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("Result written into a full queue.");

  a_base_never_full: assert property (@(posedge clk) disable iff (rst)
    level_fill[0] != FULL_FILL)
    else $error("Base bucket held at full count.");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (step_go && done && s_fin) |=> (level_fill[0] == '0 && !busy))
    else $error("State not cleared after the final word.");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("Word taken from an empty queue.");

endmodule

FILE: rtl/min_max_peak_pyramid.sv
// Top level of the min/max peak pyramid with its configuration port.
//
// Samples enter as words on the input queue (push/full); a word is taken
// when push is high and full is low. Bucket results leave through the
// result queue (empty/pop); the oldest result is on the result port while
// empty is low and is taken when pop is high. Four words of queueing sit
// on each side, so the input keeps accepting while results wait.
// Samples and results are each registered in a queue between the ports
// and the level engine. The engine handles one pyramid level per cycle
// while the result queue is not full: a sample that completes no bucket
// touches only the base level, one that completes buckets or ends the
// buffer steps through each level it touches, up to MAX_LEVELS, and the
// engine takes no new sample until it is done with the previous one.
// frame_count sets how many levels exist and is written over the APB port
// at byte address 0. Reset sets frame_count to 1 and empties both queues
// and all buckets. When the receiver stalls, the result queue fills, then
// the engine waits, then the input queue fills and full rises.
module min_max_peak_pyramid #(
  parameter int BLOCK      = mmpp_pkg::BLOCK_DEFAULT,
  parameter int MAX_LEVELS = mmpp_pkg::MAX_LEVELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mmpp_pkg::in_word_t            item,
  output logic                          full,
  input  logic                          pop,
  output mmpp_pkg::out_word_t           result,
  output logic                          empty,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmpp_pkg::ADDR_W-1:0]   paddr,
  input  logic [mmpp_pkg::DATA_W-1:0]   pwdata,
  output logic [mmpp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mmpp_pkg::*;

  localparam int LV_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam threshold_table_t THR = threshold_table(BLOCK);

  logic [DATA_W-1:0] frame_count;
  logic [LV_W-1:0]   top_lv;
  logic [LV_W-1:0]   top_lv_next;
  logic              reg_hit;
  logic              cfg_write;

  in_word_t          head;
  logic              head_empty;
  logic              head_pop;
  out_word_t         eng_word;
  logic              eng_push;
  logic              res_full;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_W-1:2] == REG_FRAME_COUNT);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? frame_count : '0;

  always_comb begin
    top_lv_next = '0;
    for (int l = 1; l < MAX_LEVELS; l++) begin
      if ({1'b0, pwdata} > THR[l]) begin
        top_lv_next = LV_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      top_lv      <= '0;
    end else if (cfg_write) begin
      frame_count <= pwdata;
      top_lv      <= top_lv_next;
    end
  end

  mmpp_fifo #(
    .WIDTH($bits(in_word_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_in_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(item),
    .full (full),
    .pop  (head_pop),
    .rdata(head),
    .empty(head_empty)
  );

  mmpp_back #(
    .BLOCK     (BLOCK),
    .MAX_LEVELS(MAX_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(!head_empty),
    .head_pop  (head_pop),
    .top_lv    (top_lv),
    .out_word  (eng_word),
    .out_push  (eng_push),
    .out_full  (res_full)
  );

  mmpp_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (eng_push),
    .wdata(eng_word),
    .full (res_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the min/max peak pyramid: directed table, random runs, APB setup.
`timescale 1ns / 1ps

module tb_top;
  import mmpp_pkg::*;

  localparam int PYR_BLOCK   = BLOCK_DEFAULT;
  localparam int PYR_LEVELS  = MAX_LEVELS_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 32;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         fin;
    bit                         typed;
    out_word_t                  want;
  } plan_row_t;

  localparam int PLAN_ROWS = 9;

  plan_row_t plan [PLAN_ROWS] = '{
    '{16'sh7fff, 1'b1, 1'b1, '{2'd0, 24'd0, 16'sh7fff, 16'sh7fff, 1'b1}},
    '{16'sh8000, 1'b1, 1'b1, '{2'd0, 24'd0, 16'sh8000, 16'sh8000, 1'b1}},
    '{16'sh0000, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh7fff, 1'b1, 1'b1, '{2'd0, 24'd0, 16'sh8000, 16'sh7fff, 1'b1}},
    '{16'sh5555, 1'b0, 1'b0, '0},
    '{16'shaaaa, 1'b1, 1'b0, '0},
    '{16'shffff, 1'b1, 1'b1, '{2'd0, 24'd0, 16'shffff, 16'shffff, 1'b1}},
    '{16'sh0001, 1'b1, 1'b1, '{2'd0, 24'd0, 16'sh0001, 16'sh0001, 1'b1}}
  };

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                push    = 1'b0;
  in_word_t            item    = '0;
  logic                full;
  logic                pop     = 1'b0;
  out_word_t           result;
  logic                empty;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [DATA_W-1:0]          cfg_frame_count = FRAME_COUNT_RESET;
  logic signed [SAMPLE_W-1:0] lvl_lo [PYR_LEVELS] = '{default: '0};
  logic signed [SAMPLE_W-1:0] lvl_hi [PYR_LEVELS] = '{default: '0};
  int unsigned                lvl_fill [PYR_LEVELS] = '{default: 0};
  logic [BUCKET_W-1:0]        lvl_count [PYR_LEVELS] = '{default: '0};

  out_word_t step_words [$];
  out_word_t bucket_q [$];

  int  mismatches     = 0;
  int  samples_sent   = 0;
  int  words_expected = 0;
  int  words_checked  = 0;
  int  settings_made  = 0;
  int  full_stalls    = 0;
  int  top_level_seen = 0;
  int  cycles         = 0;
  bit  no_idle        = 1'b0;
  bit  hold_request   = 1'b0;

  min_max_peak_pyramid DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void fold_bucket(int lv, logic signed [SAMPLE_W-1:0] lo,
                                      logic signed [SAMPLE_W-1:0] hi);
    if (lvl_fill[lv] == 0) begin
      lvl_lo[lv] = lo;
      lvl_hi[lv] = hi;
    end else begin
      if (lo < lvl_lo[lv]) lvl_lo[lv] = lo;
      if (hi > lvl_hi[lv]) lvl_hi[lv] = hi;
    end
    lvl_fill[lv]++;
  endfunction

  function automatic void emit_bucket(int lv);
    out_word_t w;
    w.level_index   = LEVEL_W'(lv);
    w.bucket_number = lvl_count[lv];
    w.bucket_min    = lvl_lo[lv];
    w.bucket_max    = lvl_hi[lv];
    w.run_end       = 1'b0;
    step_words.insert(step_words.size(), w);
    lvl_count[lv] = lvl_count[lv] + 1'b1;
    lvl_fill[lv]  = 0;
  endfunction

  // Builds the bucket words that one sample produces, in ascending level order.
  function automatic void predict_pyramid(in_word_t w);
    logic [63:0]                span;
    int                         depth;
    int                         lv;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    out_word_t                  last;
    span  = 64'(PYR_BLOCK);
    depth = 1;
    while (depth < PYR_LEVELS) begin
      span = span * 64'(PYR_BLOCK);
      if (64'(cfg_frame_count) > span) depth++;
      else break;
    end
    step_words.delete();
    fold_bucket(0, w.sample, w.sample);
    for (lv = 0; lv < depth; lv++) begin
      if (lvl_fill[lv] < PYR_BLOCK) break;
      lo = lvl_lo[lv];
      hi = lvl_hi[lv];
      emit_bucket(lv);
      if (lv + 1 < depth) fold_bucket(lv + 1, lo, hi);
    end
    if (w.final_sample) begin
      for (lv = 0; lv < depth; lv++) begin
        if (lvl_fill[lv] != 0) begin
          lo = lvl_lo[lv];
          hi = lvl_hi[lv];
          emit_bucket(lv);
          if (lv + 1 < depth) fold_bucket(lv + 1, lo, hi);
        end
      end
      for (lv = 0; lv < PYR_LEVELS; lv++) begin
        lvl_lo[lv]    = '0;
        lvl_hi[lv]    = '0;
        lvl_fill[lv]  = 0;
        lvl_count[lv] = '0;
      end
    end
    if (step_words.size() > 0) begin
      last = step_words[step_words.size() - 1];
      last.run_end = 1'b1;
      step_words[step_words.size() - 1] = last;
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    samples_sent++;
    predict_pyramid(w);
    if (typed) begin
      bucket_q.insert(bucket_q.size(), want);
      words_expected++;
    end else begin
      foreach (step_words[i]) bucket_q.insert(bucket_q.size(), step_words[i]);
      words_expected += step_words.size();
    end
  endtask

  task automatic sample_run(input int len, input bit close);
    in_word_t w;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       w.sample = 16'sh7fff;
        1:       w.sample = 16'sh8000;
        default: w.sample = SAMPLE_W'($urandom);
      endcase
      w.final_sample = close && (k == len - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // Mostly short buffers ending in a final sample, some longer ones, a few left open.
  task automatic random_runs(input int want_items, input int want_words);
    int items0;
    int words0;
    int pick;
    int len;
    int left;
    items0 = samples_sent;
    words0 = words_expected;
    while (samples_sent - items0 < want_items || words_expected - words0 < want_words) begin
      pick = $urandom_range(0, 19);
      left = want_items - (samples_sent - items0);
      if (pick < 15) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 30);
      if (left > 0 && len > left) len = left;
      sample_run(len, pick != 14);
    end
  endtask

  task automatic apb_cycle(input bit wr, input logic [DATA_W-1:0] wdata,
                           output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(REG_FRAME_COUNT) << 2;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame_count(input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    push <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_cycle(1'b1, value, readback);
    apb_cycle(1'b0, '0, readback);
    if (readback !== value) begin
      $display("%0t: frame_count readback expected %h, got %h", $time, value, readback);
      mismatches++;
    end
    cfg_frame_count = value;
    settings_made++;
  endtask

  initial begin : drain_results
    int        wait_cycles;
    out_word_t got;
    out_word_t want;
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles  = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = result;
      words_checked++;
      if (int'(got.level_index) > top_level_seen) top_level_seen = got.level_index;
      if (bucket_q.size() == 0) begin
        $display("%0t: bucket word %h arrived with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = bucket_q.pop_front();
        check_field("level_index", want.level_index, got.level_index);
        check_field("bucket_number", want.bucket_number, got.bucket_number);
        check_field("bucket_min", want.bucket_min, got.bucket_min);
        check_field("bucket_max", want.bucket_max, got.bucket_max);
        check_field("run_end", want.run_end, got.run_end);
      end
    end
  end

  initial begin : feed_samples
    in_word_t w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      w.sample       = plan[r].sample;
      w.final_sample = plan[r].fin;
      send_word(w, plan[r].typed, plan[r].want);
    end

    set_frame_count(32'd0);
    hold_request = 1'b1;
    random_runs(20, 4);

    set_frame_count(32'd65536);
    random_runs(20, 4);

    set_frame_count(32'd65537);
    random_runs(20, 4);
    sample_run(5, 1'b0);

    set_frame_count(32'h0100_0000);
    random_runs(20, 4);

    set_frame_count(32'h0100_0001);
    random_runs(20, 4);

    // Words back to back with no idle cycles on either side.
    set_frame_count(32'hffff_ffff);
    no_idle = 1'b1;
    random_runs(20, 4);
    no_idle = 1'b0;

    set_frame_count(FRAME_COUNT_RESET);
    hold_request = 1'b1;
    random_runs(20, 4);

    push <= 1'b0;
    while (bucket_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d samples and %0d bucket words over %0d frame_count settings.",
             samples_sent, words_checked, settings_made);
    $display("Highest level emitted: %0d; input held off for %0d cycles.",
             top_level_seen, full_stalls);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
